FILE: design/v2py_pkg.sv
`timescale 1ns / 1ps

package v2py_pkg;

	// datapath width of the rotation cells; inputs are scaled to about 2^46
	localparam int DATA_W       = 52;
	localparam int CORDIC_STEPS = 30;
	// prep stage, two rows of cells, output register
	localparam int PIPE_DEPTH   = 2 * CORDIC_STEPS + 2;

	// CORDIC gain, Q30
	localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

	// binary angles, 2^32 per turn
	localparam logic [31:0] TURN_0   = 32'h0000_0000;
	localparam logic [31:0] TURN_90  = 32'h4000_0000;
	localparam logic [31:0] TURN_180 = 32'h8000_0000;
	localparam logic [31:0] TURN_270 = 32'hC000_0000;

	typedef struct packed {
		logic null_vec;
		logic x_zero;
		logic x_pos;
		logic y_zero;
		logic y_pos;
		logic z_zero;
		logic z_pos;
		logic z_neg;
	} flags_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic [31:0]              ang;
	} cordic_t;

	typedef struct packed {
		flags_t            flags;
		logic [DATA_W-1:0] zk;
		logic [31:0]       yaw_ang;
	} side_t;

	// atan(2^-i), 2^32 per turn
	function automatic logic [31:0] atan_angle(input int idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			24: a = 32'd41;
			25: a = 32'd20;
			26: a = 32'd10;
			27: a = 32'd5;
			28: a = 32'd3;
			29: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: design/v2py_ifs.sv
`timescale 1ns / 1ps

interface v2py_vec_if #(parameter int COMPONENT_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] vec_x;
	logic signed [COMPONENT_BITS-1:0] vec_y;
	logic signed [COMPONENT_BITS-1:0] vec_z;

	modport source(output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink(input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface v2py_ang_if;
	logic        valid;
	logic        ready;
	logic [15:0] yaw_angle;
	logic [15:0] pitch_angle;

	modport source(output valid, output yaw_angle, output pitch_angle, input ready);
	modport sink(input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

FILE: design/v2py_prep.sv
`timescale 1ns / 1ps

module v2py_prep #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic signed [COMPONENT_BITS-1:0] vec_x,
	input  logic signed [COMPONENT_BITS-1:0] vec_y,
	input  logic signed [COMPONENT_BITS-1:0] vec_z,
	output logic                             out_valid,
	output v2py_pkg::cordic_t                out_cord,
	output v2py_pkg::side_t                  out_side
);
	import v2py_pkg::*;

	localparam int GUARD  = 47 - COMPONENT_BITS;
	localparam int ZSH    = 32 - COMPONENT_BITS;
	localparam int PROD_W = COMPONENT_BITS + 31;
	localparam int EXT_W  = DATA_W - COMPONENT_BITS - 1;

	logic                           x_neg;
	logic signed [COMPONENT_BITS:0] xe, ye, xf, yf;
	logic [DATA_W-1:0]              xw, yw;
	logic [COMPONENT_BITS-1:0]      zabs;
	logic [PROD_W-1:0]              prod;
	logic [63:0]                    zwide;
	flags_t                         fl;

	always_comb begin
		x_neg = vec_x[COMPONENT_BITS-1];
		xe    = {vec_x[COMPONENT_BITS-1], vec_x};
		ye    = {vec_y[COMPONENT_BITS-1], vec_y};
		// fold the left half-plane onto the right one
		xf    = x_neg ? -xe : xe;
		yf    = x_neg ? -ye : ye;
		xw    = {{EXT_W{xf[COMPONENT_BITS]}}, xf} << GUARD;
		yw    = {{EXT_W{yf[COMPONENT_BITS]}}, yf} << GUARD;

		zabs  = vec_z[COMPONENT_BITS-1] ? (~vec_z + 1'b1) : vec_z;
		prod  = PROD_W'(zabs) * PROD_W'(GAIN_Q30);
		zwide = 64'(prod) << ZSH;

		fl.null_vec = (vec_x == '0) && (vec_y == '0);
		fl.x_zero   = (vec_x == '0);
		fl.x_pos    = (vec_x != '0) && !vec_x[COMPONENT_BITS-1];
		fl.y_zero   = (vec_y == '0);
		fl.y_pos    = (vec_y != '0) && !vec_y[COMPONENT_BITS-1];
		fl.z_zero   = (vec_z == '0);
		fl.z_pos    = (vec_z != '0) && !vec_z[COMPONENT_BITS-1];
		fl.z_neg    = vec_z[COMPONENT_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cord.x       <= signed'(xw);
			out_cord.y       <= signed'(yw);
			out_cord.ang     <= x_neg ? TURN_180 : TURN_0;
			out_side.flags   <= fl;
			out_side.zk      <= DATA_W'(zwide >> 15);
			out_side.yaw_ang <= TURN_0;
		end
	end

endmodule

FILE: design/v2py_cell.sv
`timescale 1ns / 1ps

module v2py_cell #(
	parameter int          SHIFT = 0,
	parameter logic [31:0] ATAN  = 32'd0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  v2py_pkg::cordic_t in_cord,
	input  v2py_pkg::side_t   in_side,
	output logic              out_valid,
	output v2py_pkg::cordic_t out_cord,
	output v2py_pkg::side_t   out_side
);
	import v2py_pkg::*;

	logic signed [DATA_W-1:0] cx, cy, dx, dy;
	cordic_t                  nxt;

	// rotate towards the x axis by atan(2^-SHIFT)
	always_comb begin
		cx = in_cord.x;
		cy = in_cord.y;
		dx = cy >>> SHIFT;
		dy = cx >>> SHIFT;
		if (!cy[DATA_W-1]) begin
			nxt.x   = cx + dx;
			nxt.y   = cy - dy;
			nxt.ang = in_cord.ang + ATAN;
		end else begin
			nxt.x   = cx - dx;
			nxt.y   = cy + dy;
			nxt.ang = in_cord.ang - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_cord <= nxt;
			out_side <= in_side;
		end
	end

endmodule

FILE: design/v2py_finish.sv
`timescale 1ns / 1ps

module v2py_finish #(
	parameter int ANGLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  v2py_pkg::cordic_t in_cord,
	input  v2py_pkg::side_t   in_side,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [15:0]       yaw_angle,
	output logic [15:0]       pitch_angle
);
	import v2py_pkg::*;

	logic [31:0]           yaw32, pitch32;
	logic [ANGLE_BITS-1:0] yaw_code, pitch_raw, pitch_code;
	logic                  load;

	always_comb begin
		if (in_side.flags.null_vec) begin
			yaw32   = TURN_0;
			pitch32 = in_side.flags.z_pos ? TURN_90 : TURN_270;
		end else begin
			// exact axes override the rotation result
			if (in_side.flags.x_zero) begin
				yaw32 = in_side.flags.y_pos ? TURN_90 : TURN_270;
			end else if (in_side.flags.y_zero) begin
				yaw32 = in_side.flags.x_pos ? TURN_0 : TURN_180;
			end else begin
				yaw32 = in_side.yaw_ang;
			end
			if (in_side.flags.z_zero) begin
				pitch32 = TURN_0;
			end else if (in_side.flags.z_neg) begin
				pitch32 = TURN_0 - in_cord.ang;
			end else begin
				pitch32 = in_cord.ang;
			end
		end
		yaw_code   = yaw32[31 -: ANGLE_BITS];
		pitch_raw  = pitch32[31 -: ANGLE_BITS];
		pitch_code = ANGLE_BITS'(0) - pitch_raw;
		load       = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			yaw_angle   <= 16'(yaw_code);
			pitch_angle <= 16'(pitch_code);
		end
	end

endmodule

FILE: design/vector_to_pitch_yaw.sv
`timescale 1ns / 1ps

// Direction vector to yaw and negated pitch, as binary angles.
//
// Channels: vec takes one word per direction vector (vec_x, vec_y, vec_z,
// signed). angles returns one word per vector: yaw_angle = atan2(y, x) and
// pitch_angle = -atan2(z, |xy|), both wrapped to one turn, 2^ANGLE_BITS per
// turn, low 16 bits, truncated and within one LSB of the exact angle.
//
// Between the accepting edge and valid on angles lie one prep stage (sign
// folding and the gain multiply for z), 30 yaw rotation cells, 30 pitch
// rotation cells and the output register. Throughput is one word per cycle
// while the chain is not held; each cell holds one vector and passes it on.
//
// Reset clears every valid flag; no word is in flight afterwards.
// When the receiver stalls, the output register holds its word. The chain
// keeps advancing while its last cell is empty, so bubbles close up; once a
// word waits in the last cell as well, the whole chain and vec.ready hold.

module vector_to_pitch_yaw #(
	parameter int COMPONENT_BITS = 16,
	parameter int ANGLE_BITS     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	v2py_vec_if.sink      vec,
	v2py_ang_if.source    angles
);
	import v2py_pkg::*;

	logic                             en;
	logic signed [COMPONENT_BITS-1:0] in_x, in_y, in_z;

	// yaw chain taps [0] prep output .. [CORDIC_STEPS] last cell
	logic    yaw_v [CORDIC_STEPS+1];
	cordic_t yaw_c [CORDIC_STEPS+1];
	side_t   yaw_s [CORDIC_STEPS+1];
	// pitch chain taps
	logic    pit_v [CORDIC_STEPS+1];
	cordic_t pit_c [CORDIC_STEPS+1];
	side_t   pit_s [CORDIC_STEPS+1];

	// advance unless the last cell holds a word the output cannot take
	assign en        = !pit_v[CORDIC_STEPS] || !angles.valid || angles.ready;
	assign vec.ready = en;

	assign in_x = vec.vec_x;
	assign in_y = vec.vec_y;
	assign in_z = vec.vec_z;

	v2py_prep #(
		.COMPONENT_BITS(COMPONENT_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vec.valid),
		.vec_x    (in_x),
		.vec_y    (in_y),
		.vec_z    (in_z),
		.out_valid(yaw_v[0]),
		.out_cord (yaw_c[0]),
		.out_side (yaw_s[0])
	);

	// first pass: drive y to zero, ang accumulates yaw
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_yaw
		v2py_cell #(
			.SHIFT(k),
			.ATAN (atan_angle(k))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (yaw_v[k]),
			.in_cord  (yaw_c[k]),
			.in_side  (yaw_s[k]),
			.out_valid(yaw_v[k+1]),
			.out_cord (yaw_c[k+1]),
			.out_side (yaw_s[k+1])
		);
	end

	// hand over: horizontal length (with gain) against scaled |z|; park yaw
	always_comb begin
		pit_v[0]          = yaw_v[CORDIC_STEPS];
		pit_c[0].x        = yaw_c[CORDIC_STEPS].x;
		pit_c[0].y        = signed'(yaw_s[CORDIC_STEPS].zk);
		pit_c[0].ang      = TURN_0;
		pit_s[0]          = yaw_s[CORDIC_STEPS];
		pit_s[0].yaw_ang  = yaw_c[CORDIC_STEPS].ang;
	end

	// second pass: ang accumulates the elevation magnitude
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
		v2py_cell #(
			.SHIFT(k),
			.ATAN (atan_angle(k))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (pit_v[k]),
			.in_cord  (pit_c[k]),
			.in_side  (pit_s[k]),
			.out_valid(pit_v[k+1]),
			.out_cord (pit_c[k+1]),
			.out_side (pit_s[k+1])
		);
	end

	v2py_finish #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pit_v[CORDIC_STEPS]),
		.in_cord    (pit_c[CORDIC_STEPS]),
		.in_side    (pit_s[CORDIC_STEPS]),
		.out_ready  (angles.ready),
		.out_valid  (angles.valid),
		.yaw_angle  (angles.yaw_angle),
		.pitch_angle(angles.pitch_angle)
	);

endmodule

FILE: design/v2py_checker.sv
`timescale 1ns / 1ps

module v2py_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] yaw_angle,
	input logic [15:0] pitch_angle
);
	import v2py_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (acc_in && !acc_out) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (acc_out && !acc_in) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(yaw_angle) && $stable(pitch_angle))
		else $error("stalled result word changed or dropped");

	// no result word without a vector behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result word without an accepted vector");

	// never hold more words than the chain has places
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline places");

	// an empty output never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

endmodule

bind vector_to_pitch_yaw v2py_checker u_v2py_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vec.valid),
	.in_ready   (vec.ready),
	.out_valid  (angles.valid),
	.out_ready  (angles.ready),
	.yaw_angle  (angles.yaw_angle),
	.pitch_angle(angles.pitch_angle)
);

FILE: tb/tb_vector_to_pitch_yaw.sv
`timescale 1ns / 1ps

// Streams direction vectors through vector_to_pitch_yaw and checks every
// angle word against a local bit-exact integer CORDIC model.

module tb_vector_to_pitch_yaw;

	import v2py_pkg::*;

	localparam int COMP_W      = 16;
	// inputs are scaled up to about 2^46 before rotation
	localparam int GUARD_SHIFT = 47 - COMP_W;
	localparam int ROT_STEPS   = 30;
	localparam longint unsigned GAIN = 64'd1768195363;
	localparam int RANDOM_ITEMS = 1450;
	// no word accepted on either side for this long means the block is stuck
	localparam int QUIET_LIMIT  = 4000;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
	} vec_t;

	typedef struct packed {
		vec_t        src;
		logic [15:0] yaw;
		logic [15:0] pitch;
	} ang_t;

	typedef struct {
		longint x;
		longint y;
		longint ang;
	} rot_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// stimulus side registers, known from time zero
	logic drv_valid = 1'b0;
	vec_t drv_vec   = '0;
	logic rdy       = 1'b0;

	v2py_vec_if #(.COMPONENT_BITS(COMP_W)) vec_if();
	v2py_ang_if                            ang_if();

	assign vec_if.valid = drv_valid;
	assign vec_if.vec_x = drv_vec.x;
	assign vec_if.vec_y = drv_vec.y;
	assign vec_if.vec_z = drv_vec.z;
	assign ang_if.ready = rdy;

	vector_to_pitch_yaw dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_if),
		.angles (ang_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// atan(2^-i), 2^32 units per turn
	longint atan_step [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1
	};

	vec_t vectors_todo [$];
	ang_t angles_due   [$];
	int   errors = 0;

	int   send_gap   = 0;
	bit   send_calm  = 1'b0;
	int   recv_stall = 0;
	bit   recv_calm  = 1'b0;
	int   next_pause;
	ang_t want;
	int   quiet = 0;

	// Vectoring rotation: drive y to zero and accumulate the angle turned.
	function automatic rot_t rotate_to_axis(input longint x0, input longint y0);
		rot_t   r;
		longint dx;
		longint dy;
		int     i;
		r.x   = x0;
		r.y   = y0;
		r.ang = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = r.y >>> i;
			dy = r.x >>> i;
			if (r.y >= 0) begin
				r.x   = r.x + dx;
				r.y   = r.y - dy;
				r.ang = r.ang + atan_step[i];
			end else begin
				r.x   = r.x - dx;
				r.y   = r.y + dy;
				r.ang = r.ang - atan_step[i];
			end
		end
		return r;
	endfunction

	// Scale a magnitude by the rotation gain (Q30), split to stay in 64 bits.
	function automatic longint scale_by_gain(input longint unsigned m);
		longint unsigned hi;
		longint unsigned lo;
		hi = GAIN >> 15;
		lo = GAIN & 64'h7FFF;
		return longint'((m * hi + ((m * lo) >> 15)) >> 15);
	endfunction

	function automatic ang_t predict_angles(input vec_t v);
		ang_t            res;
		longint          x;
		longint          y;
		longint          z;
		longint          cx;
		longint          cy;
		longint          pang;
		longint unsigned zm;
		logic [31:0]     base;
		logic [31:0]     yaw32;
		logic [31:0]     pitch32;
		rot_t            hr;
		rot_t            pr;
		x    = $signed(v.x);
		y    = $signed(v.y);
		z    = $signed(v.z);
		base = TURN_0;
		if (x == 0 && y == 0) begin
			// null vector: straight up or straight down, z = 0 counts as down
			yaw32   = TURN_0;
			pitch32 = (z > 0) ? TURN_90 : TURN_270;
		end else begin
			cx = x;
			cy = y;
			// fold the left half plane onto the right one
			if (cx < 0) begin
				cx   = -cx;
				cy   = -cy;
				base = TURN_180;
			end
			hr = rotate_to_axis(cx <<< GUARD_SHIFT, cy <<< GUARD_SHIFT);
			if (x == 0)
				yaw32 = (y > 0) ? TURN_90 : TURN_270;
			else if (y == 0)
				yaw32 = (x > 0) ? TURN_0 : TURN_180;
			else
				yaw32 = base + hr.ang[31:0];

			if (z == 0) begin
				pitch32 = TURN_0;
			end else begin
				// rotated x holds the horizontal length times the gain
				zm   = longint'(z < 0 ? -z : z) << GUARD_SHIFT;
				pr   = rotate_to_axis(hr.x, scale_by_gain(zm));
				pang = (z < 0) ? -pr.ang : pr.ang;
				pitch32 = pang[31:0];
			end
		end
		res.src   = v;
		res.yaw   = yaw32[31:16];
		res.pitch = 16'd0 - pitch32[31:16];
		return res;
	endfunction

	function automatic int draw_pause(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	// Mostly full-range values, with a fair share of zeros, rails and tiny values.
	function automatic logic signed [COMP_W-1:0] pick_component();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2: return COMP_W'($signed($urandom_range(0, 6)) - 3);
			default: return COMP_W'($urandom);
		endcase
	endfunction

	task automatic log_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic queue_vector(input int x, input int y, input int z);
		vec_t v;
		v.x = COMP_W'(x);
		v.y = COMP_W'(y);
		v.z = COMP_W'(z);
		vectors_todo.push_back(v);
	endtask

	// Driver: present queued vectors, with a drawn pause after each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_vec   <= '0;
			send_gap  <= 0;
		end else begin
			// log what the block takes at this edge
			if (vec_if.valid && vec_if.ready)
				angles_due.push_back(predict_angles(drv_vec));
			// the slot is free once the held word has gone
			if (!drv_valid || vec_if.ready) begin
				if (send_gap > 0) begin
					drv_valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (vectors_todo.size() > 0) begin
					drv_valid <= 1'b1;
					drv_vec   <= vectors_todo.pop_front();
					send_gap  <= draw_pause(send_calm);
					// flip now and then between paced and back-to-back runs
					if ($urandom_range(0, 15) == 0)
						send_calm <= !send_calm;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take angle words, stall between them, check against the oldest
	// prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy        <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (ang_if.valid && ang_if.ready) begin
				if (angles_due.size() == 0) begin
					log_error($sformatf("unexpected word yaw=%h pitch=%h",
						ang_if.yaw_angle, ang_if.pitch_angle));
				end else begin
					want = angles_due.pop_front();
					if (ang_if.yaw_angle !== want.yaw)
						log_error($sformatf("yaw for (%0d,%0d,%0d): got %h want %h",
							want.src.x, want.src.y, want.src.z,
							ang_if.yaw_angle, want.yaw));
					if (ang_if.pitch_angle !== want.pitch)
						log_error($sformatf("pitch for (%0d,%0d,%0d): got %h want %h",
							want.src.x, want.src.y, want.src.z,
							ang_if.pitch_angle, want.pitch));
				end
				next_pause = draw_pause(recv_calm);
				recv_stall <= next_pause;
				rdy        <= (next_pause == 0);
				if ($urandom_range(0, 15) == 0)
					recv_calm <= !recv_calm;
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				rdy        <= (recv_stall == 1);
			end else begin
				rdy <= 1'b1;
			end
		end
	end

	// Watchdog: count edges with no word moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((vec_if.valid && vec_if.ready) || (ang_if.valid && ang_if.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		// null vectors: up, down, and z = 0 treated as down
		queue_vector(0, 0, 0);
		queue_vector(0, 0, 5);
		queue_vector(0, 0, -5);
		queue_vector(0, 0, 32767);
		queue_vector(0, 0, -32768);
		// x zero: yaw exactly a quarter or three quarters
		queue_vector(0, 100, 0);
		queue_vector(0, -100, 7);
		queue_vector(0, 32767, -32768);
		queue_vector(0, -32768, 32767);
		// y zero: yaw exactly zero or half a turn
		queue_vector(100, 0, 0);
		queue_vector(-100, 0, 50);
		queue_vector(32767, 0, -1);
		queue_vector(-32768, 0, 1);
		// z zero with a horizontal part: level pitch
		queue_vector(300, -400, 0);
		// rails of every component, then the smallest steps either way
		queue_vector(32767, 32767, 32767);
		queue_vector(-32768, -32768, -32768);
		queue_vector(-32768, 32767, -32768);
		queue_vector(32767, -32768, 32767);
		queue_vector(1, 1, 1);
		queue_vector(-1, -1, -1);
		// pitch just under level wraps near a full turn; then one small vector upward
		queue_vector(32767, 32767, -1);
		queue_vector(1000, -3, -1);
		queue_vector(-1, 1, 1);

		repeat (RANDOM_ITEMS)
			queue_vector(pick_component(), pick_component(), pick_component());

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// drain: everything sent and every prediction matched
		do
			@(posedge clk);
		while (vectors_todo.size() != 0 || drv_valid || angles_due.size() != 0);
		// watch a while longer for stray words
		repeat (PIPE_DEPTH + 40) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
